>>> design/edbv_pkg.sv
`timescale 1ns / 1ps
package edbv_pkg;

    localparam logic [63:0]        PI_Q30  = 64'd3373259426;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    localparam int SC_STAGES  = 27;
    localparam int DIV_STAGES = 4;
    localparam int TERMS      = 5;

    localparam int DS [1:TERMS] = '{6, 20, 42, 72, 110};
    localparam int DC [1:TERMS] = '{2, 12, 30, 56, 90};

    localparam logic signed [15:0] Q15_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q15_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [31:0] down;
        logic signed [31:0] east;
        logic signed [31:0] north;
    } vel_t;

endpackage

>>> design/euler_dcm_body_velocity.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the output stalls; the 35-stage
// pipeline advances any stage whose successor is empty or moving, so bubbles close
// up while the output is stalled.
// Reset: rst_n clears every stage valid bit; data registers are not reset.
module euler_dcm_body_velocity #(
    parameter int HALF_TURN_COUNTS = 32768
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, speed_north, speed_east, speed_down
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, body_u, body_v, body_w
    output logic [239:0]  m_axis_tdata
);
    localparam int G0  = edbv_pkg::SC_STAGES;
    localparam int NST = G0 + 8;

    logic [NST-1:0]       valid_reg;
    logic [NST-1:0]       adv;

    logic signed [31:0]   sr;
    logic signed [31:0]   cr;
    logic signed [31:0]   sp;
    logic signed [31:0]   cp;
    logic signed [31:0]   sy;
    logic signed [31:0]   cy;

    edbv_pkg::vel_t       vel_in;
    edbv_pkg::vel_t       vel_reg [0:G0+4];

    logic signed [63:0]   srsp_p_reg, crsp_p_reg, cpcy_p_reg, cpsy_p_reg, crsy_p_reg;
    logic signed [63:0]   crcy_p_reg, srcp_p_reg, srsy_p_reg, srcy_p_reg, crcp_p_reg;
    logic signed [31:0]   sp0_reg, cy0_reg, sy0_reg;
    logic signed [31:0]   srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, crsy_reg;
    logic signed [31:0]   crcy_reg, srcp_reg, srsy_reg, srcy_reg, crcp_reg;
    logic signed [31:0]   sp1_reg, cy1_reg, sy1_reg;
    logic signed [63:0]   q10_reg, q11_reg, q20_reg, q21_reg;
    logic signed [31:0]   cpcy2_reg, cpsy2_reg, crsy2_reg, crcy2_reg, srcp2_reg;
    logic signed [31:0]   srsy2_reg, srcy2_reg, crcp2_reg, sp2_reg;
    logic signed [33:0]   sum_reg [0:8];
    logic signed [15:0]   m_reg   [G0+4:G0+7][0:8];
    logic signed [47:0]   bp_reg  [0:8];
    logic signed [49:0]   acc_reg [0:2];
    logic signed [31:0]   body_reg [0:2];

    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                  input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (sh - 1);
        mag  = v[63] ? 64'(-v) : 64'(v);
        mag  = (mag + half) >> sh;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = rnd_sh(v, 15);
        if (r > 64'(edbv_pkg::Q15_MAX))
            return edbv_pkg::Q15_MAX;
        else if (r < 64'(edbv_pkg::Q15_MIN))
            return edbv_pkg::Q15_MIN;
        else
            return 16'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = rnd_sh(v, 15);
        if (r > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (r < -64'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(r);
    endfunction

    always_comb
    begin
        adv[NST-1] = !valid_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    edbv_sincos #(.HALF_TURN_COUNTS(HALF_TURN_COUNTS)) u_roll (
        .clk     (clk),
        .adv     (adv[G0-1:0]),
        .angle   (s_axis_tdata[15:0]),
        .sin_q30 (sr),
        .cos_q30 (cr)
    );

    edbv_sincos #(.HALF_TURN_COUNTS(HALF_TURN_COUNTS)) u_pitch (
        .clk     (clk),
        .adv     (adv[G0-1:0]),
        .angle   (s_axis_tdata[31:16]),
        .sin_q30 (sp),
        .cos_q30 (cp)
    );

    edbv_sincos #(.HALF_TURN_COUNTS(HALF_TURN_COUNTS)) u_yaw (
        .clk     (clk),
        .adv     (adv[G0-1:0]),
        .angle   (s_axis_tdata[47:32]),
        .sin_q30 (sy),
        .cos_q30 (cy)
    );

    assign vel_in.north = s_axis_tdata[79:48];
    assign vel_in.east  = s_axis_tdata[111:80];
    assign vel_in.down  = s_axis_tdata[143:112];

    always_ff @(posedge clk)
    begin
        if (adv[0])
            vel_reg[0] <= vel_in;
        for (int i = 1; i <= G0 + 4; i++)
        begin
            if (adv[i])
                vel_reg[i] <= vel_reg[i-1];
        end

        if (adv[G0])
        begin
            srsp_p_reg <= 64'(sr) * 64'(sp);
            crsp_p_reg <= 64'(cr) * 64'(sp);
            cpcy_p_reg <= 64'(cp) * 64'(cy);
            cpsy_p_reg <= 64'(cp) * 64'(sy);
            crsy_p_reg <= 64'(cr) * 64'(sy);
            crcy_p_reg <= 64'(cr) * 64'(cy);
            srcp_p_reg <= 64'(sr) * 64'(cp);
            srsy_p_reg <= 64'(sr) * 64'(sy);
            srcy_p_reg <= 64'(sr) * 64'(cy);
            crcp_p_reg <= 64'(cr) * 64'(cp);
            sp0_reg    <= sp;
            cy0_reg    <= cy;
            sy0_reg    <= sy;
        end

        if (adv[G0+1])
        begin
            srsp_reg <= 32'(rnd_sh(srsp_p_reg, 30));
            crsp_reg <= 32'(rnd_sh(crsp_p_reg, 30));
            cpcy_reg <= 32'(rnd_sh(cpcy_p_reg, 30));
            cpsy_reg <= 32'(rnd_sh(cpsy_p_reg, 30));
            crsy_reg <= 32'(rnd_sh(crsy_p_reg, 30));
            crcy_reg <= 32'(rnd_sh(crcy_p_reg, 30));
            srcp_reg <= 32'(rnd_sh(srcp_p_reg, 30));
            srsy_reg <= 32'(rnd_sh(srsy_p_reg, 30));
            srcy_reg <= 32'(rnd_sh(srcy_p_reg, 30));
            crcp_reg <= 32'(rnd_sh(crcp_p_reg, 30));
            sp1_reg  <= sp0_reg;
            cy1_reg  <= cy0_reg;
            sy1_reg  <= sy0_reg;
        end

        if (adv[G0+2])
        begin
            q10_reg   <= 64'(srsp_reg) * 64'(cy1_reg);
            q11_reg   <= 64'(srsp_reg) * 64'(sy1_reg);
            q20_reg   <= 64'(crsp_reg) * 64'(cy1_reg);
            q21_reg   <= 64'(crsp_reg) * 64'(sy1_reg);
            cpcy2_reg <= cpcy_reg;
            cpsy2_reg <= cpsy_reg;
            crsy2_reg <= crsy_reg;
            crcy2_reg <= crcy_reg;
            srcp2_reg <= srcp_reg;
            srsy2_reg <= srsy_reg;
            srcy2_reg <= srcy_reg;
            crcp2_reg <= crcp_reg;
            sp2_reg   <= sp1_reg;
        end

        if (adv[G0+3])
        begin
            sum_reg[0] <= 34'(cpcy2_reg);
            sum_reg[1] <= 34'(cpsy2_reg);
            sum_reg[2] <= -34'(sp2_reg);
            sum_reg[3] <= 34'(rnd_sh(q10_reg, 30)) - 34'(crsy2_reg);
            sum_reg[4] <= 34'(rnd_sh(q11_reg, 30)) + 34'(crcy2_reg);
            sum_reg[5] <= 34'(srcp2_reg);
            sum_reg[6] <= 34'(rnd_sh(q20_reg, 30)) + 34'(srsy2_reg);
            sum_reg[7] <= 34'(rnd_sh(q21_reg, 30)) - 34'(srcy2_reg);
            sum_reg[8] <= 34'(crcp2_reg);
        end

        if (adv[G0+4])
        begin
            for (int i = 0; i < 9; i++)
                m_reg[G0+4][i] <= to_q15(64'(sum_reg[i]));
        end

        if (adv[G0+5])
        begin
            for (int r = 0; r < 3; r++)
            begin
                bp_reg[3*r]   <= 48'(m_reg[G0+4][3*r])   * 48'(vel_reg[G0+4].north);
                bp_reg[3*r+1] <= 48'(m_reg[G0+4][3*r+1]) * 48'(vel_reg[G0+4].east);
                bp_reg[3*r+2] <= 48'(m_reg[G0+4][3*r+2]) * 48'(vel_reg[G0+4].down);
            end
            m_reg[G0+5] <= m_reg[G0+4];
        end

        if (adv[G0+6])
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= 50'(bp_reg[3*r]) + 50'(bp_reg[3*r+1]) + 50'(bp_reg[3*r+2]);
            m_reg[G0+6] <= m_reg[G0+5];
        end

        if (adv[G0+7])
        begin
            for (int r = 0; r < 3; r++)
                body_reg[r] <= sat32(64'(acc_reg[r]));
            m_reg[G0+7] <= m_reg[G0+6];
        end
    end

    assign m_axis_tdata = {body_reg[2], body_reg[1], body_reg[0],
                           m_reg[G0+7][8], m_reg[G0+7][7], m_reg[G0+7][6],
                           m_reg[G0+7][5], m_reg[G0+7][4], m_reg[G0+7][3],
                           m_reg[G0+7][2], m_reg[G0+7][1], m_reg[G0+7][0]};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off while output stage empty");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken with full pipeline and stalled output");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !valid_reg[NST-2] |=> !m_axis_tvalid)
        else $error("output transaction repeated");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[G0-1] |->
            sr <= 32'(edbv_pkg::ONE_Q30) && sr >= -32'(edbv_pkg::ONE_Q30) &&
            cp <= 32'(edbv_pkg::ONE_Q30) && cp >= -32'(edbv_pkg::ONE_Q30) &&
            sy <= 32'(edbv_pkg::ONE_Q30) && sy >= -32'(edbv_pkg::ONE_Q30))
        else $error("sine or cosine outside unit range");

endmodule

>>> design/edbv_sincos.sv
`timescale 1ns / 1ps
module edbv_sincos #(
    parameter int HALF_TURN_COUNTS = 32768
) (
    input  logic                               clk,
    input  logic [edbv_pkg::SC_STAGES-1:0]     adv,
    input  logic signed [15:0]                 angle,
    output logic signed [31:0]                 sin_q30,
    output logic signed [31:0]                 cos_q30
);
    localparam int H   = HALF_TURN_COUNTS;
    localparam int T   = 2 * H;
    localparam int PW  = $clog2(T) + 1;
    localparam logic [63:0] RECIP = (64'd1 << 33) / 64'(T);
    localparam int C0  = 32768 % T;
    localparam logic [63:0] QP = edbv_pkg::PI_Q30 / 64'(4 * H);
    localparam logic [63:0] RP = edbv_pkg::PI_Q30 % 64'(4 * H);
    localparam logic [63:0] RN = (64'd1 << 34) / 64'(4 * H);
    localparam int QB  = $clog2(H) + 1;
    localparam int NT  = edbv_pkg::TERMS;

    localparam int ST_DIV  = 4;
    localparam int ST_X    = ST_DIV + edbv_pkg::DIV_STAGES;
    localparam int ST_SQ   = ST_X + 1;
    localparam int ST_X2   = ST_X + 2;
    localparam int ST_TERM = ST_X + 3;
    localparam int ST_OUT  = edbv_pkg::SC_STAGES - 1;

    logic [15:0]          u_reg;
    logic [40:0]          mq_reg;
    logic [PW-1:0]        p_reg;
    logic [1:0]           qd_reg [2:ST_OUT-1];
    logic                 sw_reg [2:ST_OUT-1];
    logic [PW-1:0]        x4_reg;
    logic [39:0]          xa_reg [3:ST_X-1];
    logic [33:0]          nn_reg;
    logic [33:0]          nn4_reg;
    logic [33:0]          nn5_reg;
    logic [58:0]          nq_reg;
    logic [QB-1:0]        qa_reg;
    logic [QB-1:0]        qb_reg;
    logic [33:0]          rm_reg;
    logic [QB-1:0]        qf_reg;
    logic [29:0]          x_reg  [ST_X:ST_SQ];
    logic [59:0]          xx_reg;
    logic [29:0]          x2_reg [ST_X2:ST_OUT-1];
    logic [30:0]          ts_reg [0:NT];
    logic [30:0]          tc_reg [0:NT];
    logic signed [32:0]   ss_reg [0:NT];
    logic signed [32:0]   cc_reg [0:NT];
    logic [60:0]          ps_reg [1:NT];
    logic [60:0]          pc_reg [1:NT];
    logic signed [32:0]   ssa_reg [1:NT];
    logic signed [32:0]   cca_reg [1:NT];
    logic [30:0]          ns_reg [1:NT];
    logic [30:0]          nc_reg [1:NT];
    logic [61:0]          ms_reg [1:NT];
    logic [61:0]          mc_reg [1:NT];
    logic signed [32:0]   ssb_reg [1:NT];
    logic signed [32:0]   ccb_reg [1:NT];
    logic signed [31:0]   sin_reg;
    logic signed [31:0]   cos_reg;

    logic [15:0]          u_next;
    logic [7:0]           qh;
    logic [17:0]          rr0;
    logic [17:0]          rr1;
    logic [PW-1:0]        p_next;
    logic [PW+1:0]        p4;
    logic [PW+1:0]        r4;
    logic [1:0]           qd_next;
    logic                 sw_next;
    logic [PW-1:0]        x4_next;
    logic signed [31:0]   sc_s;
    logic signed [31:0]   sc_c;
    logic signed [31:0]   sw_s;
    logic signed [31:0]   sw_c;
    logic signed [31:0]   sin_next;
    logic signed [31:0]   cos_next;

    function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
        if (v < 33'sd0)
            return 32'sd0;
        else if (v > 33'(edbv_pkg::ONE_Q30))
            return 32'(edbv_pkg::ONE_Q30);
        else
            return 32'(v);
    endfunction

    always_comb
    begin
        u_next = {~angle[15], angle[14:0]};
        qh     = mq_reg[40:33];
        rr0    = 18'(u_reg) - 18'(18'(qh) * 18'(T));
        rr1    = (rr0 >= 18'(T)) ? rr0 - 18'(T) : rr0;
        p_next = (rr1 >= 18'(C0)) ? PW'(rr1 - 18'(C0)) : PW'(rr1 + 18'(T) - 18'(C0));

        p4 = {p_reg, 2'b00};
        if (p4 >= (PW+2)'(6 * H))
        begin
            qd_next = 2'd3;
            r4      = p4 - (PW+2)'(6 * H);
        end
        else if (p4 >= (PW+2)'(4 * H))
        begin
            qd_next = 2'd2;
            r4      = p4 - (PW+2)'(4 * H);
        end
        else if (p4 >= (PW+2)'(2 * H))
        begin
            qd_next = 2'd1;
            r4      = p4 - (PW+2)'(2 * H);
        end
        else
        begin
            qd_next = 2'd0;
            r4      = p4;
        end
        sw_next = r4 > (PW+2)'(H);
        x4_next = sw_next ? PW'((PW+2)'(2 * H) - r4) : PW'(r4);

        sc_s = clamp_q30(ss_reg[NT]);
        sc_c = clamp_q30(cc_reg[NT]);
        sw_s = sw_reg[ST_OUT-1] ? sc_c : sc_s;
        sw_c = sw_reg[ST_OUT-1] ? sc_s : sc_c;
        case (qd_reg[ST_OUT-1])
            2'd0:
            begin
                sin_next = sw_s;
                cos_next = sw_c;
            end
            2'd1:
            begin
                sin_next = sw_c;
                cos_next = -sw_s;
            end
            2'd2:
            begin
                sin_next = -sw_s;
                cos_next = -sw_c;
            end
            default:
            begin
                sin_next = -sw_c;
                cos_next = sw_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            u_reg  <= u_next;
            mq_reg <= 41'(u_next) * 41'(RECIP[24:0]);
        end
        if (adv[1])
            p_reg <= p_next;
        if (adv[2])
        begin
            qd_reg[2] <= qd_next;
            sw_reg[2] <= sw_next;
            x4_reg    <= x4_next;
        end
        for (int i = 3; i < ST_OUT; i++)
        begin
            if (adv[i])
            begin
                qd_reg[i] <= qd_reg[i-1];
                sw_reg[i] <= sw_reg[i-1];
            end
        end
        if (adv[3])
        begin
            xa_reg[3] <= 40'(x4_reg) * 40'(QP);
            nn_reg    <= 34'(34'(x4_reg) * 34'(RP)) + 34'(2 * H);
        end
        if (adv[ST_DIV])
        begin
            nq_reg  <= 59'(nn_reg) * 59'(RN[24:0]);
            nn4_reg <= nn_reg;
        end
        if (adv[ST_DIV+1])
        begin
            qa_reg  <= QB'(nq_reg[58:34]);
            nn5_reg <= nn4_reg;
        end
        if (adv[ST_DIV+2])
        begin
            rm_reg <= nn5_reg - 34'(34'(qa_reg) * 34'(4 * H));
            qb_reg <= qa_reg;
        end
        if (adv[ST_DIV+3])
            qf_reg <= (rm_reg >= 34'(4 * H)) ? qb_reg + QB'(1) : qb_reg;
        for (int i = ST_DIV; i < ST_X; i++)
        begin
            if (adv[i])
                xa_reg[i] <= xa_reg[i-1];
        end
        if (adv[ST_X])
            x_reg[ST_X] <= 30'(xa_reg[ST_X-1] + 40'(qf_reg));
        if (adv[ST_SQ])
        begin
            x_reg[ST_SQ] <= x_reg[ST_X];
            xx_reg       <= 60'(x_reg[ST_X]) * 60'(x_reg[ST_X]);
        end
        if (adv[ST_X2])
        begin
            x2_reg[ST_X2] <= 30'((xx_reg + 60'(64'd1 << 29)) >> 30);
            ts_reg[0]     <= 31'(x_reg[ST_SQ]);
            tc_reg[0]     <= 31'(edbv_pkg::ONE_Q30);
            ss_reg[0]     <= $signed({3'b000, x_reg[ST_SQ]});
            cc_reg[0]     <= 33'(edbv_pkg::ONE_Q30);
        end
        for (int i = ST_X2 + 1; i < ST_OUT; i++)
        begin
            if (adv[i])
                x2_reg[i] <= x2_reg[i-1];
        end
        if (adv[ST_OUT])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    for (genvar k = 1; k <= NT; k++)
    begin : g_term
        localparam int          SA  = ST_TERM + 3 * (k - 1);
        localparam logic [63:0] DSK = 64'(edbv_pkg::DS[k]);
        localparam logic [63:0] DCK = 64'(edbv_pkg::DC[k]);
        localparam logic [63:0] HDS = DSK / 2;
        localparam logic [63:0] HDC = DCK / 2;
        localparam logic [63:0] MSK = (64'd1 << 31) / DSK;
        localparam logic [63:0] MCK = (64'd1 << 31) / DCK;

        logic [30:0] ns_next;
        logic [30:0] nc_next;
        logic [30:0] qs;
        logic [30:0] qc;
        logic [30:0] rs;
        logic [30:0] rc;
        logic [30:0] ts_next;
        logic [30:0] tc_next;

        always_comb
        begin
            ns_next = 31'((ps_reg[k] + 61'(64'd1 << 29)) >> 30) + 31'(HDS);
            nc_next = 31'((pc_reg[k] + 61'(64'd1 << 29)) >> 30) + 31'(HDC);
            qs      = ms_reg[k][61:31];
            qc      = mc_reg[k][61:31];
            rs      = ns_reg[k] - 31'(qs * 31'(DSK));
            rc      = nc_reg[k] - 31'(qc * 31'(DCK));
            ts_next = (rs >= 31'(DSK)) ? qs + 31'd1 : qs;
            tc_next = (rc >= 31'(DCK)) ? qc + 31'd1 : qc;
        end

        always_ff @(posedge clk)
        begin
            if (adv[SA])
            begin
                ps_reg[k]  <= 61'(ts_reg[k-1]) * 61'(x2_reg[SA-1]);
                pc_reg[k]  <= 61'(tc_reg[k-1]) * 61'(x2_reg[SA-1]);
                ssa_reg[k] <= ss_reg[k-1];
                cca_reg[k] <= cc_reg[k-1];
            end
            if (adv[SA+1])
            begin
                ns_reg[k]  <= ns_next;
                nc_reg[k]  <= nc_next;
                ms_reg[k]  <= 62'(ns_next) * 62'(MSK[30:0]);
                mc_reg[k]  <= 62'(nc_next) * 62'(MCK[30:0]);
                ssb_reg[k] <= ssa_reg[k];
                ccb_reg[k] <= cca_reg[k];
            end
            if (adv[SA+2])
            begin
                ts_reg[k] <= ts_next;
                tc_reg[k] <= tc_next;
                if (k % 2 == 1)
                begin
                    ss_reg[k] <= ssb_reg[k] - $signed({2'b00, ts_next});
                    cc_reg[k] <= ccb_reg[k] - $signed({2'b00, tc_next});
                end
                else
                begin
                    ss_reg[k] <= ssb_reg[k] + $signed({2'b00, ts_next});
                    cc_reg[k] <= ccb_reg[k] + $signed({2'b00, tc_next});
                end
            end
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule
